>>> rtl/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Types, constants and index helpers for the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCC_W  = 4;

    typedef enum logic [1:0] {
        KIND_PUSH_REAR  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [WORD_W-1:0]  value;
    } req_word_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  data;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
    } rsp_word_t;

    typedef struct packed {
        logic                      wr_en;
        logic                      rd_en;
        logic [IDX_W-1:0]          addr;
        logic [WORD_W-1:0]         wdata;
    } ram_cmd_t;

    typedef struct packed {
        logic                      use_ram;
        logic signed [WORD_W-1:0]  data;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
    } pend_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

endpackage

>>> rtl/cdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cdq_ptr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ptr
// Front/rear indices and entry count; decodes a request into a RAM access
// and the pending response fields.
// ----------------------------------------------------------------------------
module cdq_ptr (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  cdq_pkg::req_word_t req,
    output cdq_pkg::ram_cmd_t  ram_cmd,
    output cdq_pkg::pend_t     pend
);

    import cdq_pkg::*;

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [IDX_W-1:0] rear_reg;
    logic [IDX_W-1:0] rear_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;
    ram_cmd_t         cmd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        front_next     = front_reg;
        rear_next      = rear_reg;
        count_next     = count_reg;
        cmd            = '0;
        cmd.wdata      = req.value;
        pend.use_ram   = 1'b0;
        pend.data      = '0;
        pend.status    = STAT_OK;
        unique case (req.kind)
            KIND_PUSH_REAR, KIND_PUSH_FRONT:
            begin
                if (full)
                begin
                    pend.status = STAT_FULL;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    if (empty)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        cmd.addr   = '0;
                    end
                    else if (req.kind == KIND_PUSH_REAR)
                    begin
                        rear_next = next_idx(rear_reg);
                        cmd.addr  = rear_next;
                    end
                    else
                    begin
                        front_next = prev_idx(front_reg);
                        cmd.addr   = front_next;
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_POP_FRONT, KIND_POP_REAR:
            begin
                if (empty)
                begin
                    pend.status = STAT_EMPTY;
                    pend.data   = '1;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    pend.use_ram = 1'b1;
                    cmd.addr     = (req.kind == KIND_POP_FRONT) ? front_reg : rear_reg;
                    if (count_reg == CNT_W'(1))
                    begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                    else if (req.kind == KIND_POP_FRONT)
                    begin
                        front_next = next_idx(front_reg);
                    end
                    else
                    begin
                        rear_next = prev_idx(rear_reg);
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                pend.status = STAT_OK;
            end
        endcase
        pend.occupancy = OCC_W'(count_next);
    end

    always_comb
    begin
        ram_cmd       = cmd;
        ram_cmd.wr_en = cmd.wr_en & accept;
        ram_cmd.rd_en = cmd.rd_en & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/circular_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Double-ended queue of signed words in a ring RAM; push/pop at either end.
// Response path: RAM read stage, then output register; rsp_valid is driven
//   by the output register.
// Throughput: one request per cycle while req_stall is low; the single-port
//   ring RAM serves at most one read or write per request.
// Reset: indices and count cleared; ring contents undefined until written.
// ----------------------------------------------------------------------------
module circular_double_ended_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  cdq_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cdq_pkg::rsp_word_t rsp
);

    import cdq_pkg::*;

    logic              accept;
    ram_cmd_t          ram_cmd;
    pend_t             pend;
    logic [WORD_W-1:0] rdata;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    pend_t             s1_reg;
    logic              s1_move;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_word_t         out_reg;
    rsp_word_t         out_next;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_move;
    assign accept    = req_valid && !req_stall;

    cdq_ptr u_ptr (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req     (req),
        .ram_cmd (ram_cmd),
        .pend    (pend)
    );

    cdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_cmd.wr_en),
        .re    (ram_cmd.rd_en),
        .addr  (ram_cmd.addr),
        .wdata (ram_cmd.wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        s1_valid_next      = accept || (s1_valid_reg && !s1_move);
        out_valid_next     = s1_move || (out_valid_reg && rsp_stall);
        out_next.data      = s1_reg.use_ram ? rdata : s1_reg.data;
        out_next.status    = s1_reg.status;
        out_next.occupancy = s1_reg.occupancy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= pend;
        end
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.status == STAT_FULL) |-> (s1_reg.occupancy == OCC_W'(DEPTH)))
        else $error("full status with occupancy below depth");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.status == STAT_EMPTY) |-> (s1_reg.occupancy == '0))
        else $error("empty status with nonzero occupancy");

    a_ram_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.use_ram) |-> (s1_reg.status == STAT_OK))
        else $error("RAM read data selected for a failed request");

    a_move_shows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> rsp_valid)
        else $error("pending word moved but response not valid");

endmodule
